>>> rtl/core/spo_pkg.sv
// Shared types, constants and helpers for the sphere collision push-out core.
`default_nettype none
package spo_pkg;

	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int ADDR_W  = 5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W-1:0]        umag_t;
	typedef logic [COORD_W-2:0]        ext_t;
	typedef logic [2*COORD_W-1:0]      wide_t;
	typedef logic [COORD_W:0]          den_t;
	typedef logic [COORD_W:0]          quo_t;

	localparam ext_t RADIUS_RST = ext_t'(3 << (FRAC_W - 1));

	localparam logic signed [COORD_W+1:0] SAT_HI = {3'b000, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W+1:0] SAT_LO = {3'b111, {(COORD_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_RADIUS,
		REG_SELF_TRIG,
		REG_OFF_X,
		REG_OFF_Y,
		REG_OFF_Z
	} reg_idx_t;

	typedef struct packed {
		ext_t           radius;
		logic           self_trig;
		coord_t [2:0]   off;
	} cfg_t;

	typedef struct packed {
		logic           mode;
		coord_t [2:0]   obj;
		coord_t [2:0]   other;
		ext_t   [2:0]   ext;
		logic           trig;
	} req_t;

	// Per-request context that rides along the square root and divider chains.
	typedef struct packed {
		logic           mode;
		logic           hit;
		logic           push;
		logic           nz;
		logic [2:0]     vneg;
		coord_t [2:0]   obj;
		umag_t  [2:0]   vmag;
		umag_t          rr;
	} ctx_t;

	function automatic coord_t sat_c(input logic signed [COORD_W+1:0] x);
		coord_t r;
		if (x > SAT_HI) begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (x < SAT_LO) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = x[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/spo_front.sv
// Front end: sphere centre, separation vector, squared distance and overlap test.
`default_nettype none
module spo_front
	import spo_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   in_vld,
	input  wire req_t   req,
	input  wire cfg_t   cfg,
	output logic        out_vld,
	output ctx_t        out_ctx,
	output wide_t       out_sum
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic mode_s1, push_s1;
	umag_t rr_s1;
	coord_t [2:0] obj_s1, c_s1, oth_s1;
	ext_t [2:0] ext_s1;

	logic mode_s2, push_s2;
	umag_t rr_s2;
	coord_t [2:0] obj_s2;
	ext_t [2:0] ext_s2;
	logic [2:0][COORD_W:0] d_s2;

	logic mode_s3, push_s3;
	umag_t rr_s3;
	coord_t [2:0] obj_s3;
	logic [2:0] vneg_s3;
	logic [2:0][COORD_W:0] vmag_s3;

	logic mode_s4, push_s4;
	umag_t rr_s4;
	coord_t [2:0] obj_s4;
	logic [2:0] vneg_s4;
	logic [2:0][COORD_W:0] vmag_s4;
	logic [2:0][2*COORD_W+1:0] sq_s4;
	wide_t rr2_s4;

	ctx_t ctx_s5;
	wide_t sum_s5;

	coord_t [2:0] c_n;
	logic [2:0][COORD_W:0] d_n;
	logic [2:0][COORD_W:0] vmag_n;
	logic [2:0] vneg_n;
	logic [2*COORD_W+1:0] sum_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_n[i] = sat_c({{2{req.obj[i][COORD_W-1]}}, req.obj[i]}
				+ {{2{cfg.off[i][COORD_W-1]}}, cfg.off[i]});
			d_n[i] = {c_s1[i][COORD_W-1], c_s1[i]} - {oth_s1[i][COORD_W-1], oth_s1[i]};
		end
	end

	// Box mode keeps only the part of each axis distance beyond the half extent.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [COORD_W:0] m;
			logic [COORD_W:0] e;
			m = d_s2[i][COORD_W] ? (~d_s2[i] + 1'b1) : d_s2[i];
			e = {2'b00, ext_s2[i]};
			vneg_n[i] = d_s2[i][COORD_W];
			if (mode_s2) begin
				vmag_n[i] = m;
			end else begin
				vmag_n[i] = (m > e) ? (m - e) : '0;
			end
		end
	end

	assign sum_n = sq_s4[0] + sq_s4[1] + sq_s4[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= req.mode;
			push_s1 <= !cfg.self_trig && !req.trig;
			rr_s1   <= req.mode ? (umag_t'(cfg.radius) + umag_t'(req.ext[0]))
				: umag_t'(cfg.radius);
			obj_s1  <= req.obj;
			c_s1    <= c_n;
			oth_s1  <= req.other;
			ext_s1  <= req.ext;

			mode_s2 <= mode_s1;
			push_s2 <= push_s1;
			rr_s2   <= rr_s1;
			obj_s2  <= obj_s1;
			ext_s2  <= ext_s1;
			d_s2    <= d_n;

			mode_s3 <= mode_s2;
			push_s3 <= push_s2;
			rr_s3   <= rr_s2;
			obj_s3  <= obj_s2;
			vneg_s3 <= vneg_n;
			vmag_s3 <= vmag_n;

			mode_s4 <= mode_s3;
			push_s4 <= push_s3;
			rr_s4   <= rr_s3;
			obj_s4  <= obj_s3;
			vneg_s4 <= vneg_s3;
			vmag_s4 <= vmag_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (2*COORD_W+2)'(vmag_s3[i]) * (2*COORD_W+2)'(vmag_s3[i]);
			end
			rr2_s4  <= wide_t'(rr_s3) * wide_t'(rr_s3);

			ctx_s5.mode <= mode_s4;
			ctx_s5.hit  <= sum_n < {2'b00, rr2_s4};
			ctx_s5.push <= push_s4;
			ctx_s5.nz   <= 1'b0;
			ctx_s5.vneg <= vneg_s4;
			ctx_s5.obj  <= obj_s4;
			for (int i = 0; i < 3; i++) begin
				ctx_s5.vmag[i] <= vmag_s4[i][COORD_W-1:0];
			end
			ctx_s5.rr   <= rr_s4;
			sum_s5      <= sum_n[2*COORD_W-1:0];
		end
	end

	assign out_vld = vld_s5;
	assign out_ctx = ctx_s5;
	assign out_sum = sum_s5;

endmodule
`default_nettype wire

>>> rtl/core/spo_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module spo_sqrt
	import spo_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   in_vld,
	input  wire ctx_t   in_ctx,
	input  wire wide_t  in_rad,
	output logic        out_vld,
	output ctx_t        out_ctx,
	output umag_t       out_root
);

	localparam int STG = COORD_W;

	logic             vld_sk  [STG];
	ctx_t             ctx_sk  [STG];
	logic [COORD_W:0] rem_sk  [STG];
	umag_t            root_sk [STG];
	wide_t            rad_sk  [STG];

	for (genvar k = 0; k < STG; k++) begin : g_stg
		logic             pv;
		ctx_t             pc;
		logic [COORD_W:0] pr;
		umag_t            pq;
		wide_t            pd;
		logic [COORD_W+2:0] sh;
		logic [COORD_W+3:0] diff;

		if (k == 0) begin : g_first
			assign pv = in_vld;
			assign pc = in_ctx;
			assign pr = '0;
			assign pq = '0;
			assign pd = in_rad;
		end else begin : g_next
			assign pv = vld_sk[k-1];
			assign pc = ctx_sk[k-1];
			assign pr = rem_sk[k-1];
			assign pq = root_sk[k-1];
			assign pd = rad_sk[k-1];
		end

		// Bring down the next two radicand bits and try the trial divisor 4*root+1.
		assign sh   = {pr, pd[2*COORD_W-1 -: 2]};
		assign diff = {1'b0, sh} - {2'b00, pq, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (adv) begin
				vld_sk[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_sk[k] <= pc;
				rad_sk[k] <= pd << 2;
				if (!diff[COORD_W+3]) begin
					rem_sk[k]  <= diff[COORD_W:0];
					root_sk[k] <= {pq[COORD_W-2:0], 1'b1};
				end else begin
					rem_sk[k]  <= sh[COORD_W:0];
					root_sk[k] <= {pq[COORD_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_sk[STG-1];
	assign out_ctx  = ctx_sk[STG-1];
	assign out_root = root_sk[STG-1];

endmodule
`default_nettype wire

>>> rtl/core/spo_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
`default_nettype none
module spo_div
	import spo_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_vld,
	input  wire ctx_t          in_ctx,
	input  wire wide_t [2:0]   in_num,
	input  wire den_t          in_den,
	output logic               out_vld,
	output ctx_t               out_ctx,
	output quo_t [2:0]         out_quo
);

	localparam int STG = COORD_W + 1;

	logic                  vld_sk [STG];
	ctx_t                  ctx_sk [STG];
	den_t                  den_sk [STG];
	logic [2:0][COORD_W:0] rem_sk [STG];
	logic [2:0][COORD_W:0] num_sk [STG];
	quo_t [2:0]            quo_sk [STG];

	for (genvar k = 0; k < STG; k++) begin : g_stg
		logic                  pv;
		ctx_t                  pc;
		den_t                  pd;
		logic [2:0][COORD_W:0] pr;
		logic [2:0][COORD_W:0] pn;
		quo_t [2:0]            pq;
		logic [2:0][COORD_W:0] nr;
		logic [2:0]            ge;

		if (k == 0) begin : g_first
			assign pv = in_vld;
			assign pc = in_ctx;
			assign pd = in_den;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				// The quotient fits COORD_W+1 bits, so the top bits start as the remainder.
				assign pr[i] = {2'b00, in_num[i][2*COORD_W-1:COORD_W+1]};
				assign pn[i] = in_num[i][COORD_W:0];
				assign pq[i] = '0;
			end
		end else begin : g_next
			assign pv = vld_sk[k-1];
			assign pc = ctx_sk[k-1];
			assign pd = den_sk[k-1];
			assign pr = rem_sk[k-1];
			assign pn = num_sk[k-1];
			assign pq = quo_sk[k-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				logic [COORD_W+1:0] r;
				logic [COORD_W+1:0] s;
				r = {pr[i], pn[i][COORD_W]};
				s = r - {1'b0, pd};
				ge[i] = r >= {1'b0, pd};
				nr[i] = ge[i] ? s[COORD_W:0] : r[COORD_W:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (adv) begin
				vld_sk[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctx_sk[k] <= pc;
				den_sk[k] <= pd;
				rem_sk[k] <= nr;
				for (int i = 0; i < 3; i++) begin
					num_sk[k][i] <= pn[i] << 1;
					quo_sk[k][i] <= {pq[i][COORD_W-1:0], ge[i]};
				end
			end
		end
	end

	assign out_vld = vld_sk[STG-1];
	assign out_ctx = ctx_sk[STG-1];
	assign out_quo = quo_sk[STG-1];

endmodule
`default_nettype wire

>>> rtl/core/sphere_collision_push_out_core.sv
// One request per cycle from request to result, unless a valid output is stalled.
// The square root (one bit per stage) and the divider (one quotient bit per stage) set the depth.
// Every stage advances together; the whole pipeline holds while a valid output is stalled.
// Reset clears all valid bits, sets radius to 1.5 and clears self_trigger and the offsets.
// Top level: configuration port, pipeline stages and output register.
`default_nettype none
module sphere_collision_push_out_core
	import spo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire coord_t             obj_x,
	input  wire coord_t             obj_y,
	input  wire coord_t             obj_z,
	input  wire coord_t             other_x,
	input  wire coord_t             other_y,
	input  wire coord_t             other_z,
	input  wire ext_t               extent_x,
	input  wire ext_t               extent_y,
	input  wire ext_t               extent_z,
	input  wire logic               other_trigger,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    hit,
	output coord_t                  new_x,
	output coord_t                  new_y,
	output coord_t                  new_z
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic adv;
	req_t req;

	logic  fr_vld;
	ctx_t  fr_ctx;
	wide_t fr_sum;

	logic  sq_vld;
	ctx_t  sq_ctx;
	umag_t sq_root;
	ctx_t  ctx_n;

	logic  vld_s6;
	ctx_t  ctx_s6;
	umag_t gap_s6;
	den_t  den_s6;

	logic         vld_s7;
	ctx_t         ctx_s7;
	den_t         den_s7;
	wide_t [2:0]  num_s7;

	logic        dv_vld;
	ctx_t        dv_ctx;
	quo_t [2:0]  dv_quo;

	logic         vld_s8;
	logic         hit_s8;
	coord_t [2:0] new_s8;
	coord_t [2:0] new_n;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius    <= RADIUS_RST;
			cfg_q.self_trig <= 1'b0;
			cfg_q.off       <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_RADIUS:    cfg_q.radius    <= pwdata[COORD_W-2:0];
				REG_SELF_TRIG: cfg_q.self_trig <= pwdata[0];
				REG_OFF_X:     cfg_q.off[0]    <= pwdata;
				REG_OFF_Y:     cfg_q.off[1]    <= pwdata;
				REG_OFF_Z:     cfg_q.off[2]    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RADIUS:    prdata = {1'b0, cfg_q.radius};
			REG_SELF_TRIG: prdata = {31'd0, cfg_q.self_trig};
			REG_OFF_X:     prdata = cfg_q.off[0];
			REG_OFF_Y:     prdata = cfg_q.off[1];
			REG_OFF_Z:     prdata = cfg_q.off[2];
			default:       prdata = '0;
		endcase
	end

	assign adv      = !(vld_s8 && out_stall);
	assign in_stall = !adv;

	assign req.mode     = mode;
	assign req.obj      = {obj_z, obj_y, obj_x};
	assign req.other    = {other_z, other_y, other_x};
	assign req.ext      = {extent_z, extent_y, extent_x};
	assign req.trig     = other_trigger;

	spo_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.req     (req),
		.cfg     (cfg_q),
		.out_vld (fr_vld),
		.out_ctx (fr_ctx),
		.out_sum (fr_sum)
	);

	spo_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.in_ctx   (fr_ctx),
		.in_rad   (fr_sum),
		.out_vld  (sq_vld),
		.out_ctx  (sq_ctx),
		.out_root (sq_root)
	);

	// On a hit the distance is below the combined radius, so the gap never wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= sq_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= dv_vld;
		end
	end

	always_comb begin
		ctx_n    = sq_ctx;
		ctx_n.nz = sq_root != '0;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [COORD_W+1:0] o;
			logic signed [COORD_W+1:0] q;
			o = {{2{dv_ctx.obj[i][COORD_W-1]}}, dv_ctx.obj[i]};
			q = {1'b0, dv_quo[i]};
			if (dv_ctx.hit && dv_ctx.push && dv_ctx.nz) begin
				new_n[i] = sat_c(dv_ctx.vneg[i] ? (o - q) : (o + q));
			end else begin
				new_n[i] = dv_ctx.obj[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6    <= ctx_n;
			gap_s6    <= sq_ctx.rr - sq_root;
			den_s6    <= sq_ctx.mode ? {sq_root, 1'b0} : {1'b0, sq_root};

			ctx_s7 <= ctx_s6;
			den_s7 <= den_s6;
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= wide_t'(ctx_s6.vmag[i]) * wide_t'(gap_s6);
			end

			hit_s8 <= dv_ctx.hit;
			new_s8 <= new_n;
		end
	end

	spo_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s7),
		.in_ctx  (ctx_s7),
		.in_num  (num_s7),
		.in_den  (den_s7),
		.out_vld (dv_vld),
		.out_ctx (dv_ctx),
		.out_quo (dv_quo)
	);

	assign out_valid = vld_s8;
	assign hit       = hit_s8;
	assign new_x     = new_s8[0];
	assign new_y     = new_s8[1];
	assign new_z     = new_s8[2];

endmodule
`default_nettype wire
